// ----- sv/kmcs_pkg.sv -----
// ----------------------------------------------------------------------------
// Key matrix change scanner package
// Shared types, widths and helper functions for the scanner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package kmcs_pkg;

  localparam int MAX_ROWS = 8;
  localparam int ROW_W    = 3;
  localparam int KCOL_W   = 4;

  typedef logic [MAX_ROWS-1:0] row_bits_t;
  typedef logic [ROW_W-1:0]    row_idx_t;
  typedef logic [KCOL_W-1:0]   key_col_t;

  typedef struct packed {
    row_bits_t mask;
    row_bits_t now;
    key_col_t  col;
  } pend_t;

  function automatic row_idx_t lowest_set(input row_bits_t mask);
    row_idx_t idx;
    idx = '0;
    for (int r = MAX_ROWS - 1; r >= 0; r--) begin
      if (mask[r]) begin
        idx = ROW_W'(r);
      end
    end
    return idx;
  endfunction

  function automatic row_bits_t clear_lowest(input row_bits_t mask);
    return mask & (mask - row_bits_t'(1));
  endfunction

endpackage

`default_nettype wire

// ----- sv/key_matrix_change_scanner.sv -----
// ----------------------------------------------------------------------------
// Key matrix change scanner
// Turns active-low column samples into key press and release items.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    row_lines[7:0]
//   out_     output     out_valid / out_ready  key_row, key_column,
//                                              is_pressed, last_event
//
// A column sample is accepted on the input handshake; each changed row then
// yields one output item per cycle while the output is not stalled, a rate
// set by the one-event-per-cycle emitter.
// The next sample is accepted in the cycle the final event is registered.
// Reset clears all column states to released and restarts at column 0.
// A stalled output holds its item and the emitter waits.
// ----------------------------------------------------------------------------
`default_nettype none

module key_matrix_change_scanner import kmcs_pkg::*; #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_row_lines,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_key_row,
  output logic [3:0]      out_key_column,
  output logic            out_is_pressed,
  output logic            out_last_event
);

  pend_t pend;
  logic  take;

  kmcs_capture #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_capture (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_row_lines(in_row_lines),
    .take        (take),
    .pend        (pend)
  );

  kmcs_emitter u_emitter (
    .clk           (clk),
    .rst_n         (rst_n),
    .pend          (pend),
    .take          (take),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_key_row   (out_key_row),
    .out_key_column(out_key_column),
    .out_is_pressed(out_is_pressed),
    .out_last_event(out_last_event)
  );

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(pend.mask) > 1) |-> !in_ready)
    else $error("sample accepted while several events are pending");

  a_more_after_nonlast: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_event) |-> (pend.mask != '0))
    else $error("non-final event shown with nothing left pending");

  a_take_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> (pend.mask != '0))
    else $error("emitter took an event with no pending change");

  a_take_makes_valid: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid)
    else $error("taken event did not appear on the output");

endmodule

`default_nettype wire

// ----- sv/kmcs_capture.sv -----
// ----------------------------------------------------------------------------
// Key matrix column capture
// Compares a column sample with the stored column state, updates the state,
// advances the scan column and holds the changed rows for the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module kmcs_capture import kmcs_pkg::*; #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_row_lines,
  input  wire logic       take,
  output pend_t           pend
);

  localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam row_bits_t ROW_KEEP = row_bits_t'((16'd1 << ROWS) - 16'd1);

  logic [COL_W-1:0] col_r, col_nxt;
  row_bits_t        prev_r [COLUMNS];
  pend_t            pend_r, pend_nxt;
  row_bits_t        now_w;
  logic             accept;
  logic             single;

  assign now_w    = ~in_row_lines & ROW_KEEP;
  assign single   = (pend_r.mask != '0) && (clear_lowest(pend_r.mask) == '0);
  assign in_ready = (pend_r.mask == '0) || (take && single);
  assign accept   = in_valid && in_ready;
  assign pend     = pend_r;

  always_comb begin
    col_nxt = col_r;
    if (accept) begin
      if (col_r == COL_W'(COLUMNS - 1)) begin
        col_nxt = '0;
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (accept) begin
      pend_nxt.mask = now_w ^ prev_r[col_r];
      pend_nxt.now  = now_w;
      pend_nxt.col  = key_col_t'(col_r);
    end else if (take) begin
      pend_nxt.mask = clear_lowest(pend_r.mask);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      pend_r <= '0;
      for (int c = 0; c < COLUMNS; c++) begin
        prev_r[c] <= '0;
      end
    end else begin
      col_r  <= col_nxt;
      pend_r <= pend_nxt;
      if (accept) begin
        prev_r[col_r] <= now_w;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/kmcs_emitter.sv -----
// ----------------------------------------------------------------------------
// Key matrix event emitter
// Picks the lowest pending changed row each cycle and registers it as one key
// event whenever the output is empty or being taken, holding it until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module kmcs_emitter import kmcs_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire pend_t  pend,
  output logic        take,
  output logic        out_valid,
  input  wire logic   out_ready,
  output row_idx_t    out_key_row,
  output key_col_t    out_key_column,
  output logic        out_is_pressed,
  output logic        out_last_event
);

  logic     valid_r, valid_nxt;
  row_idx_t row_r;
  key_col_t col_r;
  logic     pressed_r;
  logic     last_r;
  row_idx_t pick;

  assign pick = lowest_set(pend.mask);
  assign take = (pend.mask != '0) && (!valid_r || out_ready);

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      row_r     <= pick;
      col_r     <= pend.col;
      pressed_r <= pend.now[pick];
      last_r    <= (clear_lowest(pend.mask) == '0);
    end
  end

  assign out_valid      = valid_r;
  assign out_key_row    = row_r;
  assign out_key_column = col_r;
  assign out_is_pressed = pressed_r;
  assign out_last_event = last_r;

endmodule

`default_nettype wire

// ----- bench/key_matrix_change_scanner_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Key matrix change scanner testbench
// Drives active-low column samples through the valid/ready input and checks
// every key event item against a local scan model, under random sender gaps,
// a random receiver stall and one long receiver hold-off.
// ----------------------------------------------------------------------------

module key_matrix_change_scanner_tb import kmcs_pkg::*; ();

  localparam int COLUMNS = 16;
  localparam int ROWS = 8;
  localparam row_bits_t ROW_KEEP = row_bits_t'((1 << ROWS) - 1);
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DIRECTED_COUNT = 20;
  localparam row_bits_t DIRECTED_SAMPLES [DIRECTED_COUNT] = '{
    8'hFF, 8'h00, 8'hFE, 8'h7F, 8'hAA, 8'h55, 8'hF0, 8'h0F, 8'hFF, 8'h00,
    8'hEF, 8'hF7, 8'hBD, 8'hDB, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFE, 8'hFF
  };

  typedef struct packed {
    row_idx_t row;
    key_col_t col;
    logic     pressed;
    logic     last;
  } key_event_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_row_lines;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] out_key_row;
  logic [3:0] out_key_column;
  logic       out_is_pressed;
  logic       out_last_event;

  key_event_t  due_key_events[$];
  key_event_t  head_event;
  row_bits_t   column_keys [COLUMNS];
  int unsigned model_col;
  row_bits_t   raw_seen [COLUMNS];
  int unsigned tx_col;
  int unsigned burst_left;
  bit          sender_gaps;
  bit          rx_free;
  bit          hold_request;
  int unsigned rx_run_left;
  bit          rx_run_level;
  int unsigned error_count;
  int unsigned cycle_count;

  key_matrix_change_scanner #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_row_lines  (in_row_lines),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_key_row   (out_key_row),
    .out_key_column(out_key_column),
    .out_is_pressed(out_is_pressed),
    .out_last_event(out_last_event)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void compare_column_sample(input row_bits_t lines);
    row_bits_t   pressed_now;
    row_bits_t   changed;
    int unsigned remaining;
    key_event_t  ev;
    pressed_now = ~lines & ROW_KEEP;
    changed = pressed_now ^ column_keys[model_col];
    remaining = $countones(changed);
    for (int r = 0; r < ROWS; r++) begin
      if (changed[r]) begin
        remaining--;
        ev.row = row_idx_t'(r);
        ev.col = key_col_t'(model_col);
        ev.pressed = pressed_now[r];
        ev.last = (remaining == 0);
        due_key_events.push_back(ev);
      end
    end
    column_keys[model_col] = pressed_now;
    model_col = (model_col + 1 == COLUMNS) ? 0 : model_col + 1;
  endfunction

  function automatic row_bits_t typing_sample(input row_bits_t prior);
    row_bits_t   s;
    int unsigned pick;
    s = prior;
    pick = $urandom_range(0, 9);
    if (pick >= 4 && pick < 8) begin
      s[$urandom_range(0, ROWS - 1)] ^= 1'b1;
    end else if (pick == 8) begin
      s[$urandom_range(0, ROWS - 1)] ^= 1'b1;
      s[$urandom_range(0, ROWS - 1)] ^= 1'b1;
    end else if (pick == 9) begin
      s = row_bits_t'($urandom);
    end
    return s;
  endfunction

  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_valid === 1'b1 && in_ready === 1'b1) begin
      compare_column_sample(in_row_lines);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (due_key_events.size() == 0) begin
        $display("%0t: unexpected key event row %0d column %0d pressed %0b last %0b",
                 $time, out_key_row, out_key_column, out_is_pressed, out_last_event);
        error_count++;
      end else begin
        head_event = due_key_events.pop_front();
        if (out_key_row !== head_event.row) begin
          $display("%0t: key_row expected %0d, got %0d", $time, head_event.row, out_key_row);
          error_count++;
        end
        if (out_key_column !== head_event.col) begin
          $display("%0t: key_column expected %0d, got %0d",
                   $time, head_event.col, out_key_column);
          error_count++;
        end
        if (out_is_pressed !== head_event.pressed) begin
          $display("%0t: is_pressed expected %0b, got %0b",
                   $time, head_event.pressed, out_is_pressed);
          error_count++;
        end
        if (out_last_event !== head_event.last) begin
          $display("%0t: last_event expected %0b, got %0b",
                   $time, head_event.last, out_last_event);
          error_count++;
        end
      end
    end
  end

  initial begin
    rx_run_left = 0;
    rx_run_level = 1'b1;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (rx_free) begin
        out_ready <= 1'b1;
      end else begin
        if (rx_run_left == 0) begin
          rx_run_level = ($urandom_range(0, 2) != 0);
          rx_run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                    : $urandom_range(1, 5);
        end
        rx_run_left--;
        out_ready <= rx_run_level;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d key events outstanding", $time, due_key_events.size());
      $display("FAIL key_matrix_change_scanner");
      $finish;
    end
  end

  task automatic offer_sample(input row_bits_t lines);
    in_valid <= 1'b1;
    in_row_lines <= lines;
    raw_seen[tx_col] = lines;
    tx_col = (tx_col + 1 == COLUMNS) ? 0 : tx_col + 1;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (sender_gaps) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 10);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_key_events.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    rx_free = 1'b1;
    sender_gaps = 1'b0;
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      offer_sample(DIRECTED_SAMPLES[i]);
    end
    wait_drained();
  endtask

  task automatic test_typing();
    rx_free = 1'b0;
    sender_gaps = 1'b1;
    for (int i = 0; i < 110; i++) begin
      offer_sample(typing_sample(raw_seen[tx_col]));
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    rx_free = 1'b1;
    sender_gaps = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 20; i++) begin
      offer_sample(row_bits_t'($urandom));
    end
    wait_drained();
    rx_free = 1'b0;
    for (int i = 0; i < 10; i++) begin
      offer_sample(~raw_seen[tx_col]);
    end
    wait_drained();
  endtask

  task automatic test_noise();
    rx_free = 1'b0;
    sender_gaps = 1'b0;
    for (int i = 0; i < 60; i++) begin
      if (i == 20) begin
        sender_gaps = 1'b1;
      end
      offer_sample(row_bits_t'($urandom));
    end
    wait_drained();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_row_lines <= '0;
    error_count = 0;
    cycle_count = 0;
    model_col = 0;
    tx_col = 0;
    burst_left = 0;
    sender_gaps = 1'b0;
    rx_free = 1'b1;
    hold_request = 1'b0;
    for (int c = 0; c < COLUMNS; c++) begin
      column_keys[c] = '0;
      raw_seen[c] = '1;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_typing();
    test_backpressure();
    test_noise();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_key_events.size() != 0) begin
      $display("%0t: %0d key events never arrived", $time, due_key_events.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("PASS key_matrix_change_scanner");
    end else begin
      $display("FAIL key_matrix_change_scanner");
    end
    $finish;
  end

endmodule
